// ----- sv/gn2_pkg.sv -----
package gn2_pkg;

  // Field widths fixed by the item format.
  localparam int CELLW  = 6;
  localparam int IDXW   = 12;
  localparam int GW     = 16;
  localparam int NORMW  = 17;
  localparam int FRACW  = 16;
  localparam int CORDW  = NORMW + CELLW - FRACW;
  localparam int POSW   = NORMW + CELLW;
  localparam int SCALEW = 16;
  localparam int OUTW   = 16;
  localparam int CFGW   = 16;
  localparam int CFGIW  = 2;
  localparam int PRODW  = 34;
  localparam int DOTW   = 35;

  // Largest cell count a configuration write may set.
  localparam logic [CELLW-1:0] MAX_CELLS = 6'd63;
  localparam logic [CELLW-1:0] CELLS_RESET = 6'd1;
  localparam logic [SCALEW-1:0] SCALE_RESET = 16'd23757;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef enum logic [CFGIW-1:0] {
    CFG_CELLS_X = 2'd0,
    CFG_CELLS_Y = 2'd1,
    CFG_SCALE   = 2'd2
  } cfg_idx_t;

  // Per-point control that travels beside the corner data.
  typedef struct packed {
    logic             vld;
    logic             eval;
    logic             oog;
    logic [FRACW-1:0] fx;
    logic [FRACW-1:0] fy;
  } pt_meta_t;

endpackage

// ----- sv/gn2_if.sv -----
interface gn2_in_if;
  import gn2_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [IDXW-1:0]        corner_index;
  logic signed [GW-1:0]   grad_x;
  logic signed [GW-1:0]   grad_y;
  logic [NORMW-1:0]       norm_x;
  logic [NORMW-1:0]       norm_y;
  modport source (output valid, op, corner_index, grad_x, grad_y, norm_x, norm_y,
                  input ready);
  modport sink (input valid, op, corner_index, grad_x, grad_y, norm_x, norm_y,
                output ready);
endinterface

interface gn2_out_if;
  import gn2_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [OUTW-1:0] noise_value;
  logic                   out_of_grid;
  modport source (output valid, noise_value, out_of_grid, input ready);
  modport sink (input valid, noise_value, out_of_grid, output ready);
endinterface

// ----- sv/gn2_ram.sv -----
module gn2_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/gn2_addr.sv -----
module gn2_addr #(
  parameter int STORE_DEPTH = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_vld,
  input  logic                              in_op,
  input  logic [gn2_pkg::IDXW-1:0]          in_corner_index,
  input  logic signed [gn2_pkg::GW-1:0]     in_grad_x,
  input  logic signed [gn2_pkg::GW-1:0]     in_grad_y,
  input  logic [gn2_pkg::NORMW-1:0]         in_norm_x,
  input  logic [gn2_pkg::NORMW-1:0]         in_norm_y,
  input  logic [gn2_pkg::CELLW-1:0]         cells_x,
  input  logic [gn2_pkg::CELLW-1:0]         cells_y,
  output gn2_pkg::pt_meta_t                 meta,
  output logic [$clog2(STORE_DEPTH)-1:0]    rd_addr [4],
  output logic                              wr_en,
  output logic [$clog2(STORE_DEPTH)-1:0]    wr_addr,
  output logic [2*gn2_pkg::GW-1:0]          wr_data
);
  import gn2_pkg::*;

  localparam int AW   = $clog2(STORE_DEPTH);
  localparam int RW   = ((AW > IDXW) ? AW : IDXW) + 1;
  localparam int KSH  = 24;
  localparam int MREC = ((1 << KSH) + STORE_DEPTH - 1) / STORE_DEPTH;
  localparam int MULW = IDXW + KSH + 1;

  // Stage 1: scale the coordinates by the cell counts.
  logic                    a1_v_r, a1_op_r;
  logic [IDXW-1:0]         a1_ci_r;
  logic [2*GW-1:0]         a1_g_r;
  logic [POSW-1:0]         a1_px_r, a1_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_v_r <= 1'b0;
    end else if (adv) begin
      a1_v_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_op_r <= in_op;
      a1_ci_r <= in_corner_index;
      a1_g_r  <= {in_grad_y, in_grad_x};
      a1_px_r <= POSW'(in_norm_x) * POSW'(cells_x);
      a1_py_r <= POSW'(in_norm_y) * POSW'(cells_y);
    end
  end

  // Stage 2: grid check and index of the lower left corner.
  logic [CORDW-1:0]   a2_cx, a2_cy;
  logic [2*CORDW-1:0] a2_lin;
  logic               a2_v_r, a2_op_r, a2_oog_r;
  logic [IDXW-1:0]    a2_ci_r, a2_i00_r;
  logic [2*GW-1:0]    a2_g_r;
  logic [FRACW-1:0]   a2_fx_r, a2_fy_r;

  always_comb begin
    a2_cx  = a1_px_r[POSW-1:FRACW];
    a2_cy  = a1_py_r[POSW-1:FRACW];
    a2_lin = (2*CORDW)'(a2_cy) * (2*CORDW)'({1'b0, cells_x} + 7'd1) + (2*CORDW)'(a2_cx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a2_v_r <= 1'b0;
    end else if (adv) begin
      a2_v_r <= a1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a2_op_r  <= a1_op_r;
      a2_ci_r  <= a1_ci_r;
      a2_g_r   <= a1_g_r;
      a2_fx_r  <= a1_px_r[FRACW-1:0];
      a2_fy_r  <= a1_py_r[FRACW-1:0];
      a2_oog_r <= (a2_cx >= {1'b0, cells_x}) || (a2_cy >= {1'b0, cells_y});
      a2_i00_r <= a2_lin[IDXW-1:0];
    end
  end

  // Stage 3: the four corner indices.
  logic [IDXW-1:0]  a3_row;
  logic             a3_v_r, a3_op_r, a3_oog_r;
  logic [IDXW-1:0]  a3_ci_r;
  logic [2*GW-1:0]  a3_g_r;
  logic [FRACW-1:0] a3_fx_r, a3_fy_r;
  logic [IDXW-1:0]  a3_idx_r [4];

  assign a3_row = IDXW'(cells_x) + IDXW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a3_v_r <= 1'b0;
    end else if (adv) begin
      a3_v_r <= a2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a3_op_r     <= a2_op_r;
      a3_ci_r     <= a2_ci_r;
      a3_g_r      <= a2_g_r;
      a3_fx_r     <= a2_fx_r;
      a3_fy_r     <= a2_fy_r;
      a3_oog_r    <= a2_oog_r;
      a3_idx_r[0] <= a2_i00_r;
      a3_idx_r[1] <= a2_i00_r + IDXW'(1);
      a3_idx_r[2] <= a2_i00_r + a3_row;
      a3_idx_r[3] <= a2_i00_r + a3_row + IDXW'(1);
    end
  end

  // Stage 4: quotient by the store depth, through a reciprocal multiply.
  logic             a4_v_r, a4_op_r, a4_oog_r;
  logic [IDXW-1:0]  a4_ci_r;
  logic [2*GW-1:0]  a4_g_r;
  logic [FRACW-1:0] a4_fx_r, a4_fy_r;
  logic [IDXW-1:0]  a4_idx_r [4];
  logic [IDXW-1:0]  a4_q_r [4];
  logic [MULW-1:0]  a4_prod [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      a4_prod[k] = MULW'(a3_idx_r[k]) * MULW'(MREC);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a4_v_r <= 1'b0;
    end else if (adv) begin
      a4_v_r <= a3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a4_op_r  <= a3_op_r;
      a4_ci_r  <= a3_ci_r;
      a4_g_r   <= a3_g_r;
      a4_fx_r  <= a3_fx_r;
      a4_fy_r  <= a3_fy_r;
      a4_oog_r <= a3_oog_r;
      for (int k = 0; k < 4; k++) begin
        a4_idx_r[k] <= a3_idx_r[k];
        a4_q_r[k]   <= a4_prod[k][KSH+IDXW-1:KSH];
      end
    end
  end

  // Remainder with a final correction gives the memory addresses.
  logic [RW-1:0] rem [4];
  logic [RW-1:0] wr_wide;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rem[k] = RW'(a4_idx_r[k]) - RW'(a4_q_r[k]) * RW'(STORE_DEPTH);
      if (rem[k] >= RW'(STORE_DEPTH)) begin
        rem[k] = rem[k] - RW'(STORE_DEPTH);
      end
      rd_addr[k] = rem[k][AW-1:0];
    end
  end

  // A load writes at the same stage as the corner reads, so order is kept.
  assign wr_wide = RW'(a4_ci_r);
  assign wr_en   = adv && a4_v_r && (op_t'(a4_op_r) == OP_LOAD)
                   && (32'(a4_ci_r) < STORE_DEPTH);
  assign wr_addr = wr_wide[AW-1:0];
  assign wr_data = a4_g_r;

  always_comb begin
    meta.vld  = a4_v_r;
    meta.eval = (op_t'(a4_op_r) == OP_EVAL);
    meta.oog  = a4_oog_r;
    meta.fx   = a4_fx_r;
    meta.fy   = a4_fy_r;
  end

endmodule

// ----- sv/gn2_blend.sv -----
module gn2_blend (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  gn2_pkg::pt_meta_t                  meta_in,
  input  logic [2*gn2_pkg::GW-1:0]           grad [4],
  input  logic [gn2_pkg::SCALEW-1:0]         output_scale,
  output logic                               out_vld,
  output logic signed [gn2_pkg::OUTW-1:0]    out_noise,
  output logic                               out_oog
);
  import gn2_pkg::*;

  localparam int NST = 8;
  localparam int BW  = 2*DOTW - 17;
  localparam int MW  = DOTW + 17;

  pt_meta_t m_r [NST];

  // Control travels beside the arithmetic; stage 0 lines up with memory data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) begin
        m_r[k] <= '0;
      end
    end else if (adv) begin
      m_r[0] <= meta_in;
      for (int k = 1; k < NST; k++) begin
        m_r[k] <= m_r[k-1];
      end
    end
  end

  // Stage 1: offset times gradient for each corner, and the squares of the fractions.
  logic signed [17:0]      dx0, dx1, dy0, dy1;
  logic signed [17:0]      dxk [4];
  logic signed [17:0]      dyk [4];
  logic signed [PRODW-1:0] px_r [4];
  logic signed [PRODW-1:0] py_r [4];
  logic [31:0]             ffx_r, ffy_r;

  always_comb begin
    dx0 = {2'b00, m_r[0].fx};
    dx1 = {2'b11, m_r[0].fx};
    dy0 = {2'b00, m_r[0].fy};
    dy1 = {2'b11, m_r[0].fy};
    dxk[0] = dx0; dyk[0] = dy0;
    dxk[1] = dx1; dyk[1] = dy0;
    dxk[2] = dx0; dyk[2] = dy1;
    dxk[3] = dx1; dyk[3] = dy1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        px_r[k] <= PRODW'(dxk[k]) * PRODW'($signed(grad[k][GW-1:0]));
        py_r[k] <= PRODW'(dyk[k]) * PRODW'($signed(grad[k][2*GW-1:GW]));
      end
      ffx_r <= 32'(m_r[0].fx) * 32'(m_r[0].fx);
      ffy_r <= 32'(m_r[0].fy) * 32'(m_r[0].fy);
    end
  end

  // Stage 2: dot products and smoothstep weights.
  logic signed [DOTW-1:0] d_r [4];
  logic [FRACW-1:0]       sx_r, sy_r;
  logic [17:0]            tx, ty;
  logic [49:0]            smx, smy;

  always_comb begin
    tx  = 18'd196608 - {1'b0, m_r[1].fx, 1'b0};
    ty  = 18'd196608 - {1'b0, m_r[1].fy, 1'b0};
    smx = 50'(ffx_r) * 50'(tx);
    smy = 50'(ffy_r) * 50'(ty);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        d_r[k] <= DOTW'(px_r[k]) + DOTW'(py_r[k]);
      end
      sx_r <= smx[47:32];
      sy_r <= smy[47:32];
    end
  end

  // Stage 3: weighted differences along x.
  logic signed [BW-1:0]   bx0_r, bx1_r;
  logic signed [DOTW-1:0] a0_r, a1_r;
  logic [FRACW-1:0]       sy3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      bx0_r <= BW'(DOTW'(d_r[1] - d_r[0])) * BW'($signed({1'b0, sx_r}));
      bx1_r <= BW'(DOTW'(d_r[3] - d_r[2])) * BW'($signed({1'b0, sx_r}));
      a0_r  <= d_r[0];
      a1_r  <= d_r[2];
      sy3_r <= sy_r;
    end
  end

  // Stage 4: finish the two x blends.
  logic signed [DOTW-1:0] r0_r, r1_r;
  logic [FRACW-1:0]       sy4_r;
  logic signed [BW-1:0]   bx0_s, bx1_s;

  assign bx0_s = bx0_r >>> FRACW;
  assign bx1_s = bx1_r >>> FRACW;

  always_ff @(posedge clk) begin
    if (adv) begin
      r0_r  <= a0_r + bx0_s[DOTW-1:0];
      r1_r  <= a1_r + bx1_s[DOTW-1:0];
      sy4_r <= sy3_r;
    end
  end

  // Stage 5: weighted difference along y.
  logic signed [BW-1:0]   by_r;
  logic signed [DOTW-1:0] r0b_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      by_r  <= BW'(DOTW'(r1_r - r0_r)) * BW'($signed({1'b0, sy4_r}));
      r0b_r <= r0_r;
    end
  end

  // Stage 6: finish the y blend.
  logic signed [DOTW-1:0] r_r;
  logic signed [BW-1:0]   by_s;

  assign by_s = by_r >>> FRACW;

  always_ff @(posedge clk) begin
    if (adv) begin
      r_r <= r0b_r + by_s[DOTW-1:0];
    end
  end

  // Stage 7: apply the output gain.
  logic signed [MW-1:0] mm_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      mm_r <= MW'(r_r) * MW'($signed({1'b0, output_scale}));
    end
  end

  // Output register: round half up to Q3.12 and saturate.
  logic signed [MW-1:0]      rnd;
  logic signed [MW-33:0]     vq;
  logic signed [OUTW-1:0]    vsat;
  logic                      out_vld_r, out_oog_r;
  logic signed [OUTW-1:0]    out_noise_r;

  always_comb begin
    rnd = mm_r + MW'(64'sd2147483648);
    vq  = rnd[MW-1:32];
    if (vq > (MW-32)'(32767)) begin
      vsat = 16'sh7FFF;
    end else if (vq < -(MW-32)'(32768)) begin
      vsat = 16'sh8000;
    end else begin
      vsat = vq[OUTW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= m_r[NST-1].vld && m_r[NST-1].eval;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_oog_r   <= m_r[NST-1].oog;
      out_noise_r <= m_r[NST-1].oog ? '0 : vsat;
    end
  end

  assign out_vld   = out_vld_r;
  assign out_noise = out_noise_r;
  assign out_oog   = out_oog_r;

endmodule

// ----- sv/gradient_noise_2d_eval.sv -----
// Throughput: one item per cycle while the output is not stalled; the gradient table is held in four copies so
// the four corners of a point are read in the same cycle.
// A stalled output holds the whole pipeline. Reset (rst_n, synchronous) clears
// pipeline valid bits and sets cells_x = cells_y = 1 and the default gain.
// The gradient table is not cleared by reset; corners must be loaded before use.
module gradient_noise_2d_eval #(
  parameter int STORE_DEPTH = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  gn2_in_if.sink                      in_item,
  gn2_out_if.source                   out_item,
  input  logic                        cfg_we,
  input  logic [gn2_pkg::CFGIW-1:0]   cfg_index,
  input  logic [gn2_pkg::CFGW-1:0]    cfg_data
);
  import gn2_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  // Configuration registers.
  logic [CELLW-1:0]  cells_x_r, cells_y_r, cells_nxt;
  logic [SCALEW-1:0] scale_r;

  always_comb begin
    cells_nxt = cfg_data[CELLW-1:0];
    if (cells_nxt > MAX_CELLS) begin
      cells_nxt = MAX_CELLS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_x_r <= CELLS_RESET;
      cells_y_r <= CELLS_RESET;
      scale_r   <= SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CELLS_X: cells_x_r <= cells_nxt;
        CFG_CELLS_Y: cells_y_r <= cells_nxt;
        CFG_SCALE:   scale_r   <= cfg_data[SCALEW-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is free or being taken.
  logic adv, out_vld;

  assign adv           = !out_vld || out_item.ready;
  assign in_item.ready = adv;

  pt_meta_t          meta;
  logic [AW-1:0]     rd_addr [4];
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [2*GW-1:0]   wr_data;
  logic [2*GW-1:0]   grad [4];

  gn2_addr #(.STORE_DEPTH(STORE_DEPTH)) u_addr (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .in_vld          (in_item.valid && adv),
    .in_op           (in_item.op),
    .in_corner_index (in_item.corner_index),
    .in_grad_x       (in_item.grad_x),
    .in_grad_y       (in_item.grad_y),
    .in_norm_x       (in_item.norm_x),
    .in_norm_y       (in_item.norm_y),
    .cells_x         (cells_x_r),
    .cells_y         (cells_y_r),
    .meta            (meta),
    .rd_addr         (rd_addr),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data)
  );

  // One copy of the gradient table per cell corner.
  for (genvar k = 0; k < 4; k++) begin : g_bank
    gn2_ram #(.WIDTH(2*GW), .DEPTH(STORE_DEPTH)) u_ram (
      .clk   (clk),
      .we    (wr_en),
      .waddr (wr_addr),
      .wdata (wr_data),
      .re    (adv),
      .raddr (rd_addr[k]),
      .rdata (grad[k])
    );
  end

  gn2_blend u_blend (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .meta_in      (meta),
    .grad         (grad),
    .output_scale (scale_r),
    .out_vld      (out_vld),
    .out_noise    (out_item.noise_value),
    .out_oog      (out_item.out_of_grid)
  );

  assign out_item.valid = out_vld;

endmodule

// ----- sv/gn2_check.sv -----
module gn2_check (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [gn2_pkg::OUTW-1:0]  out_noise_value,
  input logic                             out_out_of_grid
);

  // A waiting item is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // Nothing is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item offered straight after reset");

  // A point off the grid always reads as zero.
  a_oog_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_grid |-> out_noise_value == '0)
    else $error("off-grid result carries a non-zero value");

  // With the output register empty the block always takes input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output register is empty");

  // After an input is taken with the output register empty, input stalls next cycle only if a result waits.
  a_take_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> in_ready || out_valid)
    else $error("input stalled with no result waiting");

endmodule

bind gradient_noise_2d_eval gn2_check u_gn2_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_item.valid),
  .in_ready        (in_item.ready),
  .out_valid       (out_item.valid),
  .out_ready       (out_item.ready),
  .out_noise_value (out_item.noise_value),
  .out_out_of_grid (out_item.out_of_grid)
);
